/* rtl/tlbclk_pkg.sv */
// Shared types and constants for the fully associative TLB with clock replacement.
// Used by the controller, the datapath and the top level; no dependencies.
package tlbclk_pkg;

	localparam int FRAME_W   = 20;
	localparam int SLOT_W    = 4;
	localparam int HIT_CNT_W = 32;
	localparam int CFG_W     = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// m_tdata: frame, slot, hit_total, padded to whole bytes
	localparam int M_DATA_W = ((FRAME_W + SLOT_W + HIT_CNT_W + 7) / 8) * 8;
	localparam int M_USER_W = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;          // capture the input item
		logic lookup_done;   // hit or free entry: update and emit result
		logic sweep_start;   // miss with table full: load sweep pointer
		logic sweep_advance; // clear used bit at pointer, step pointer
		logic sweep_done;    // victim at pointer: fill and emit result
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic lu_hit;
		logic lu_free;
		logic victim_clear;
		logic out_free;
	} ctl_sts_t;

endpackage

/* rtl/tlbclk_ctrl.sv */
// Controller state machine for the TLB: idle, lookup and clock sweep.
// Depends on tlbclk_pkg for the state enum and the command/status structs.
module tlbclk_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  tlbclk_pkg::ctl_sts_t sts,
	output tlbclk_pkg::ctl_cmd_t cmd
);

	tlbclk_pkg::ctl_state_t state_q;
	tlbclk_pkg::ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlbclk_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tlbclk_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = tlbclk_pkg::ST_LOOKUP;
				end
			end
			tlbclk_pkg::ST_LOOKUP: begin
				if (sts.lu_hit || sts.lu_free) begin
					if (sts.out_free) begin
						state_nxt = tlbclk_pkg::ST_IDLE;
					end
				end else begin
					state_nxt = tlbclk_pkg::ST_SWEEP;
				end
			end
			tlbclk_pkg::ST_SWEEP: begin
				if (sts.victim_clear && sts.out_free) begin
					state_nxt = tlbclk_pkg::ST_IDLE;
				end
			end
			default: state_nxt = tlbclk_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			tlbclk_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			tlbclk_pkg::ST_LOOKUP: begin
				if (sts.lu_hit || sts.lu_free) begin
					cmd.lookup_done = sts.out_free;
				end else begin
					cmd.sweep_start = 1'b1;
				end
			end
			tlbclk_pkg::ST_SWEEP: begin
				if (sts.victim_clear) begin
					cmd.sweep_done = sts.out_free;
				end else begin
					cmd.sweep_advance = 1'b1;
				end
			end
			default: begin
				cmd      = '0;
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/tlbclk_datapath.sv */
// TLB datapath: entry storage, parallel tag compare, clock sweep pointer,
// hit counter, configuration register and result register. Uses tlbclk_pkg.
module tlbclk_datapath #(
	parameter int TLB_DEPTH = 16,
	parameter int PAGE_BITS = 20
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr,
	input  logic [tlbclk_pkg::CFG_W-1:0]         cfg_data,
	input  tlbclk_pkg::ctl_cmd_t                 cmd,
	output tlbclk_pkg::ctl_sts_t                 sts,
	input  logic [PAGE_BITS-1:0]                 in_page,
	input  logic                                 in_write,
	input  logic [PAGE_BITS-1:0]                 in_refill,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output logic                                 out_hit,
	output logic [tlbclk_pkg::FRAME_W-1:0]       out_frame,
	output logic [tlbclk_pkg::SLOT_W-1:0]        out_slot,
	output logic                                 out_dirty,
	output logic [tlbclk_pkg::HIT_CNT_W-1:0]     out_total
);

	localparam int IDX_W = $clog2(TLB_DEPTH);
	localparam int NW    = $clog2(TLB_DEPTH + 1);

	logic [PAGE_BITS-1:0] tag_q   [TLB_DEPTH];
	logic [PAGE_BITS-1:0] frame_q [TLB_DEPTH];
	logic [TLB_DEPTH-1:0] valid_q;
	logic [TLB_DEPTH-1:0] used_q;
	logic [TLB_DEPTH-1:0] dirty_q;
	logic [IDX_W-1:0]     hand_q;
	logic [IDX_W-1:0]     pos_q;
	logic [tlbclk_pkg::HIT_CNT_W-1:0] hit_cnt_q;
	logic [tlbclk_pkg::CFG_W-1:0]     entries_q;

	logic [PAGE_BITS-1:0] page_q;
	logic                 wr_q;
	logic [PAGE_BITS-1:0] refill_q;

	logic [NW-1:0]        active_n;
	logic [TLB_DEPTH-1:0] hit_vec;
	logic [TLB_DEPTH-1:0] free_vec;
	logic                 lu_hit;
	logic                 lu_free;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     free_idx;
	logic [IDX_W-1:0]     sel_idx;
	logic [IDX_W-1:0]     pos_nxt;
	logic [IDX_W-1:0]     start_pos;
	logic                 do_fill;
	logic                 do_finish;
	logic                 is_hit;
	logic [tlbclk_pkg::HIT_CNT_W-1:0] hit_cnt_nxt;

	// zero behaves as one entry, values above the built depth saturate
	always_comb begin
		if (entries_q == '0) begin
			active_n = NW'(1);
		end else if (int'(entries_q) > TLB_DEPTH) begin
			active_n = NW'(TLB_DEPTH);
		end else begin
			active_n = NW'(entries_q);
		end
	end

	always_comb begin
		for (int k = 0; k < TLB_DEPTH; k++) begin
			hit_vec[k]  = (k < int'(active_n)) && valid_q[k] && (tag_q[k] == page_q);
			free_vec[k] = (k < int'(active_n)) && !valid_q[k];
		end
	end

	// lowest matching and lowest free entry
	always_comb begin
		lu_hit   = 1'b0;
		lu_free  = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int k = TLB_DEPTH - 1; k >= 0; k--) begin
			if (hit_vec[k]) begin
				lu_hit  = 1'b1;
				hit_idx = IDX_W'(k);
			end
			if (free_vec[k]) begin
				lu_free  = 1'b1;
				free_idx = IDX_W'(k);
			end
		end
	end

	always_comb begin
		start_pos = (int'(hand_q) < int'(active_n)) ? hand_q : '0;
		pos_nxt   = ((int'(pos_q) + 1) == int'(active_n)) ? '0 : IDX_W'(pos_q + 1'b1);
	end

	assign is_hit    = cmd.lookup_done && lu_hit;
	assign do_fill   = (cmd.lookup_done && !lu_hit) || cmd.sweep_done;
	assign do_finish = cmd.lookup_done || cmd.sweep_done;
	assign sel_idx   = cmd.sweep_done ? pos_q : (lu_hit ? hit_idx : free_idx);
	assign hit_cnt_nxt = hit_cnt_q + tlbclk_pkg::HIT_CNT_W'(is_hit);

	assign sts.lu_hit       = lu_hit;
	assign sts.lu_free      = lu_free;
	assign sts.victim_clear = !used_q[pos_q];
	assign sts.out_free     = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			used_q    <= '0;
			dirty_q   <= '0;
			hand_q    <= '0;
			pos_q     <= '0;
			hit_cnt_q <= '0;
			entries_q <= tlbclk_pkg::CFG_RESET;
			m_tvalid  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				entries_q <= cfg_data;
			end
			if (cmd.sweep_start) begin
				pos_q <= start_pos;
			end
			if (cmd.sweep_advance) begin
				used_q[pos_q] <= 1'b0;
				pos_q         <= pos_nxt;
			end
			if (do_finish) begin
				hand_q          <= sel_idx;
				used_q[sel_idx] <= 1'b1;
				hit_cnt_q       <= hit_cnt_nxt;
				if (do_fill) begin
					valid_q[sel_idx] <= 1'b1;
					dirty_q[sel_idx] <= wr_q;
				end else if (wr_q) begin
					dirty_q[sel_idx] <= 1'b1;
				end
			end
			if (do_finish) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q   <= in_page;
			wr_q     <= in_write;
			refill_q <= in_refill;
		end
		if (do_fill) begin
			tag_q[sel_idx]   <= page_q;
			frame_q[sel_idx] <= refill_q;
		end
		if (do_finish) begin
			out_hit   <= is_hit;
			out_frame <= tlbclk_pkg::FRAME_W'(is_hit ? frame_q[hit_idx] : refill_q);
			out_slot  <= tlbclk_pkg::SLOT_W'(sel_idx);
			out_dirty <= wr_q;
			out_total <= hit_cnt_nxt;
		end
	end

endmodule

/* rtl/tlb_lookup_clock_replace_top.sv */
// Fully associative TLB with clock replacement: top level, stream ports and packing.
// An item is taken only in idle; on a hit or a fill of a free entry the result is registered from the
// lookup state. A full-table miss first loads the sweep pointer, then steps past each used entry, clearing
// its used bit, until it finds a clear one. A new item waits until the last result is registered, and a
// held result stalls the lookup or the sweep. Reset (arst_n low, async): entries invalid, used/dirty clear,
// hand and hit count zero, entries_in_use = 16. Depends on tlbclk_pkg, tlbclk_ctrl, tlbclk_datapath.
module tlb_lookup_clock_replace_top #(
	parameter int TLB_DEPTH = 16,
	parameter int PAGE_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,

	// configuration: entries_in_use
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tlbclk_pkg::CFG_W-1:0]  cfg_data,

	// input items
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// bits up: virtual_page, refill_frame, zero padding
	input  logic [((2 * PAGE_BITS + 7) / 8) * 8-1:0] s_tdata,
	// bit 0: is_write
	input  logic                                   s_tuser,

	// result items
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// bits up: frame[19:0], slot[23:20], hit_total[55:24]
	output logic [tlbclk_pkg::M_DATA_W-1:0]    m_tdata,
	// bit 0: hit, bit 1: mark_table_dirty
	output logic [tlbclk_pkg::M_USER_W-1:0]    m_tuser
);

	tlbclk_pkg::ctl_cmd_t cmd;
	tlbclk_pkg::ctl_sts_t sts;

	logic                                 out_hit;
	logic [tlbclk_pkg::FRAME_W-1:0]       out_frame;
	logic [tlbclk_pkg::SLOT_W-1:0]        out_slot;
	logic                                 out_dirty;
	logic [tlbclk_pkg::HIT_CNT_W-1:0]     out_total;

	// register writes should land only while idle (the user's rule, not enforced); cfg_ready is tied high
	assign cfg_ready = 1'b1;

	tlbclk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlbclk_datapath #(
		.TLB_DEPTH (TLB_DEPTH),
		.PAGE_BITS (PAGE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.in_page   (s_tdata[PAGE_BITS-1:0]),
		.in_write  (s_tuser),
		.in_refill (s_tdata[2*PAGE_BITS-1:PAGE_BITS]),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.out_hit   (out_hit),
		.out_frame (out_frame),
		.out_slot  (out_slot),
		.out_dirty (out_dirty),
		.out_total (out_total)
	);

	// result packing, lowest field first
	assign m_tdata = tlbclk_pkg::M_DATA_W'({out_total, out_slot, out_frame});
	assign m_tuser = {out_dirty, out_hit};

endmodule
